@@ rtl/lphp_pkg.sv @@
// ----------------------------------------------------------------------------
// lphp_pkg: shared types and constants
// Field codes, protocol numbers and the summary word of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none
package lphp_pkg;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] TYPE_ARP  = 16'h0806;

  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;

  localparam logic [1:0] NET_IPV4  = 2'd0;
  localparam logic [1:0] NET_IPV6  = 2'd1;
  localparam logic [1:0] NET_ARP   = 2'd2;
  localparam logic [1:0] NET_OTHER = 2'd3;

  localparam logic [1:0] TRN_TCP   = 2'd0;
  localparam logic [1:0] TRN_UDP   = 2'd1;
  localparam logic [1:0] TRN_ICMP  = 2'd2;
  localparam logic [1:0] TRN_OTHER = 2'd3;

  localparam logic [2:0] APP_UNKNOWN  = 3'd0;
  localparam logic [2:0] APP_HTTP     = 3'd1;
  localparam logic [2:0] APP_HTTPS    = 3'd2;
  localparam logic [2:0] APP_DNS      = 3'd3;
  localparam logic [2:0] APP_SSH      = 3'd4;
  localparam logic [2:0] APP_FTP      = 3'd5;
  localparam logic [2:0] APP_SMTP     = 3'd6;
  localparam logic [2:0] APP_FTP_DATA = 3'd7;

  typedef struct packed {
    logic        truncated;
    logic [1:0]  network_kind;
    logic [15:0] link_protocol;
    logic [1:0]  transport_kind;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [5:0]  tcp_flag_bits;
    logic [7:0]  hop_count;
    logic [1:0]  fragment_flags;
    logic [15:0] arp_operation;
    logic [15:0] payload_length;
    logic [2:0]  application_class;
  } summary_t;

  // Frame state captured so far, handed to the summary stage.
  typedef struct packed {
    logic [15:0] byte_position;
    logic [15:0] protocol_field;
    logic [5:0]  network_header_bytes;
    logic [15:0] network_length_field;
    logic [7:0]  next_protocol;
    logic [7:0]  hop_register;
    logic [1:0]  fragment_register;
    logic [15:0] arp_register;
    logic [31:0] port_pair;
    logic [5:0]  flag_register;
    logic [5:0]  transport_header_bytes;
    logic [15:0] udp_length_field;
  } frame_state_t;

  function automatic logic [2:0] app_class(input logic [15:0] sp, input logic [15:0] dp);
    if (sp == 16'd80 || dp == 16'd80) return APP_HTTP;
    if (sp == 16'd443 || dp == 16'd443) return APP_HTTPS;
    if (sp == 16'd53 || dp == 16'd53) return APP_DNS;
    if (sp == 16'd22 || dp == 16'd22) return APP_SSH;
    if (sp == 16'd21 || dp == 16'd21) return APP_FTP;
    if (sp == 16'd25 || dp == 16'd25) return APP_SMTP;
    if (sp == 16'd20) return APP_FTP_DATA;
    return APP_UNKNOWN;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lphp_if.sv @@
// ----------------------------------------------------------------------------
// lphp_byte_if / lphp_sum_if: stream channels
// Valid/ready channels for frame bytes and summary words.
// ----------------------------------------------------------------------------
`default_nettype none
interface lphp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface lphp_sum_if import lphp_pkg::*;;
  logic     valid;
  logic     ready;
  summary_t sum;
  modport source (output valid, sum, input ready);
  modport sink (input valid, sum, output ready);
endinterface
`default_nettype wire

@@ rtl/lphp_summary.sv @@
// ----------------------------------------------------------------------------
// lphp_summary: summary word builder
// Turn the captured frame state into the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
module lphp_summary import lphp_pkg::*; (
  input  wire frame_state_t st,
  input  wire logic         link_kind,
  output summary_t          sum
);
  logic [15:0] hdr;
  logic signed [17:0] len;
  logic v4;

  always_comb begin
    hdr = link_kind ? 16'd16 : 16'd14;
    v4 = st.protocol_field == TYPE_IPV4;
    sum = '0;
    len = '0;
    sum.network_kind = NET_OTHER;
    sum.transport_kind = TRN_OTHER;
    if (st.byte_position < hdr) begin
      sum.truncated = 1'b1;
    end else begin
      sum.link_protocol = st.protocol_field;
      if (v4 || st.protocol_field == TYPE_IPV6) begin
        sum.network_kind = v4 ? NET_IPV4 : NET_IPV6;
        sum.hop_count = st.hop_register;
        if (v4) sum.fragment_flags = st.fragment_register;
        if (st.next_protocol == PROTO_TCP) begin
          sum.transport_kind = TRN_TCP;
          sum.source_port = st.port_pair[31:16];
          sum.destination_port = st.port_pair[15:0];
          sum.tcp_flag_bits = st.flag_register;
          len = $signed({2'b00, st.network_length_field})
              - $signed({12'd0, st.transport_header_bytes})
              - (v4 ? $signed({12'd0, st.network_header_bytes}) : 18'sd0);
        end else if (st.next_protocol == PROTO_UDP) begin
          sum.transport_kind = TRN_UDP;
          sum.source_port = st.port_pair[31:16];
          sum.destination_port = st.port_pair[15:0];
          len = $signed({2'b00, st.udp_length_field}) - 18'sd8;
        end else if (st.next_protocol == (v4 ? PROTO_ICMP : PROTO_ICMP6)) begin
          sum.transport_kind = TRN_ICMP;
        end
        if (len > 18'sd0) begin
          sum.payload_length = len[15:0];
          sum.application_class = app_class(sum.source_port, sum.destination_port);
        end
      end else if (st.protocol_field == TYPE_ARP) begin
        sum.network_kind = NET_ARP;
        sum.arp_operation = st.arp_register;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/lphp_capture.sv @@
// ----------------------------------------------------------------------------
// lphp_capture: per-byte field capture
// Update the frame state from one byte, selected by its position.
// ----------------------------------------------------------------------------
`default_nettype none
module lphp_capture import lphp_pkg::*; (
  input  wire frame_state_t st,
  input  wire logic         link_kind,
  input  wire logic [7:0]   b,
  output frame_state_t      st_next
);
  logic [15:0] hdr, p, r, t;
  logic v4, v6;

  always_comb begin
    st_next = st;
    p = st.byte_position;
    hdr = link_kind ? 16'd16 : 16'd14;
    r = p - hdr;
    if (p == hdr - 16'd2 || p == hdr - 16'd1) begin
      st_next.protocol_field = {st.protocol_field[7:0], b};
      if (p == hdr - 16'd1 && {st.protocol_field[7:0], b} == TYPE_IPV6)
        st_next.network_header_bytes = 6'd40;
    end
    v4 = st_next.protocol_field == TYPE_IPV4;
    v6 = st_next.protocol_field == TYPE_IPV6;
    t = r - {10'd0, st_next.network_header_bytes};
    if (p >= hdr) begin
      if (v4) begin
        if (r == 16'd0) st_next.network_header_bytes = {b[3:0], 2'b00};
        else if (r == 16'd2 || r == 16'd3)
          st_next.network_length_field = {st.network_length_field[7:0], b};
        else if (r == 16'd6) st_next.fragment_register = b[6:5];
        else if (r == 16'd8) st_next.hop_register = b;
        else if (r == 16'd9) st_next.next_protocol = b;
      end else if (v6) begin
        if (r == 16'd4 || r == 16'd5)
          st_next.network_length_field = {st.network_length_field[7:0], b};
        else if (r == 16'd6) st_next.next_protocol = b;
        else if (r == 16'd7) st_next.hop_register = b;
      end else if (st_next.protocol_field == TYPE_ARP) begin
        if (r == 16'd6 || r == 16'd7)
          st_next.arp_register = {st.arp_register[7:0], b};
      end
      // Transport offset uses the header length including an IHL taken from this byte.
      if ((v4 || v6) && r >= {10'd0, st_next.network_header_bytes}) begin
        t = r - {10'd0, st_next.network_header_bytes};
        if (t < 16'd4) st_next.port_pair = {st.port_pair[23:0], b};
        else if (t == 16'd4 || t == 16'd5)
          st_next.udp_length_field = {st.udp_length_field[7:0], b};
        else if (t == 16'd12) st_next.transport_header_bytes = {b[7:4], 2'b00};
        else if (t == 16'd13) st_next.flag_register = b[5:0];
      end
    end
    if (p != 16'hFFFF) st_next.byte_position = p + 16'd1;
  end
endmodule
`default_nettype wire

@@ rtl/layered_packet_header_parser.sv @@
// ----------------------------------------------------------------------------
// layered_packet_header_parser: Ethernet/cooked, IPv4/IPv6/ARP, TCP/UDP parser
// Byte-stream header parser that gives one summary word per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in  : one frame byte per word, last_byte marks the final byte.
//   out : one summary word per frame, issued after the final byte.
//   link_kind_we/link_kind_wdata select Ethernet (0) or cooked (1) framing;
//   write only while no frame is in flight.
// Throughput: one byte per cycle unless a final byte is held (see Stall); each
//   byte updates the frame state held in registers, so bytes stream back to back.
// Output: the summary word is valid in the cycle after the final byte is
//   accepted; the summary is built from the updated state and registered.
// Stall: the output register holds its word while out.ready is low; in.ready
//   stays high while the output register is empty or being drained, so a
//   final byte waits only when a previous summary is still unclaimed.
// Reset: clears link_kind to Ethernet, the frame state and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module layered_packet_header_parser import lphp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   link_kind_we,
  input  wire logic   link_kind_wdata,
  lphp_byte_if.sink   in,
  lphp_sum_if.source  out
);
  logic         link_kind;
  frame_state_t st, st_next;
  summary_t     sum_next;
  logic         out_valid;
  summary_t     out_sum;
  logic         take;

  // Accept a byte unless a final byte would overwrite an unclaimed summary.
  assign in.ready = !out_valid || out.ready || !in.last_byte;
  assign take = in.valid && in.ready;

  lphp_capture u_capture (
    .st(st), .link_kind(link_kind), .b(in.data_byte), .st_next(st_next)
  );
  lphp_summary u_summary (
    .st(st_next), .link_kind(link_kind), .sum(sum_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind <= 1'b0;
      st <= '0;
      out_valid <= 1'b0;
    end else begin
      if (link_kind_we) link_kind <= link_kind_wdata;
      if (take && in.last_byte) begin
        // Issue the summary and clear the state for the next frame.
        st <= '0;
        out_valid <= 1'b1;
      end else begin
        if (take) st <= st_next;
        if (out.ready) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && in.last_byte) out_sum <= sum_next;
  end

  assign out.valid = out_valid;
  assign out.sum = out_sum;

`ifndef ASSERT_OFF
  a_final_sets_valid: assert property (@(posedge clk) disable iff (rst)
    take && in.last_byte |=> out_valid) else $error("summary not issued");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out.ready |-> !(take && in.last_byte)) else $error("summary lost");
  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    take && in.last_byte |=> st.byte_position == 16'd0) else $error("state not cleared");
`endif
endmodule
`default_nettype wire
